// File: hw/rtl/dce_pkg.sv
// Shared types, codes and scale tables for the diatonic chord expander.
`default_nettype none
package dce_pkg;

    localparam int DCE_QUEUE_DEPTH = 4;
    localparam int CHORD_TONES     = 6;

    // op codes of an incoming event
    localparam logic [1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF = 2'd1;

    // configuration register indexes
    localparam logic CFG_BASE_KEY       = 1'b0;
    localparam logic CFG_TARGET_CHANNEL = 1'b1;

    localparam logic [6:0] BASE_KEY_RESET       = 7'd60;
    localparam logic [3:0] TARGET_CHANNEL_RESET = 4'd0;
    localparam logic [8:0] OCTAVE_BIAS          = 9'd132;
    localparam logic [8:0] TOP_NOTE             = 9'd127;

    // floor(v / 12) == (v * 171) >> 11 for all v below 260
    localparam logic [7:0] MOD12_RECIP = 8'd171;
    localparam int         MOD12_SHIFT = 11;
    localparam logic [3:0] SEMIS_OCTAVE = 4'd12;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] channel;
        logic [6:0] note_key;
        logic [6:0] velocity;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [3:0] out_channel;
        logic [6:0] out_key;
        logic [6:0] out_velocity;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [6:0] base_key;
        logic [3:0] target_channel;
    } t_cfg;

    typedef struct packed {
        logic       hit;
        logic [2:0] deg;
    } t_deg_hit;

    // one expanded event waiting for the tone generator
    typedef struct packed {
        logic              kind;
        logic [3:0]        channel;
        logic [6:0]        velocity;
        logic [2:0]        deg;
        logic signed [7:0] root;
    } t_job;

    function automatic logic [3:0] degree_offset(input logic [2:0] deg);
        logic [3:0] r;
        unique case (deg)
            3'd0:    r = 4'd0;
            3'd1:    r = 4'd2;
            3'd2:    r = 4'd4;
            3'd3:    r = 4'd5;
            3'd4:    r = 4'd7;
            3'd5:    r = 4'd9;
            3'd6:    r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic t_deg_hit pitch_degree(input logic [3:0] pc);
        t_deg_hit r;
        r.hit = 1'b1;
        unique case (pc)
            4'd0:    r.deg = 3'd0;
            4'd2:    r.deg = 3'd1;
            4'd4:    r.deg = 3'd2;
            4'd5:    r.deg = 3'd3;
            4'd7:    r.deg = 3'd4;
            4'd9:    r.deg = 3'd5;
            4'd11:   r.deg = 3'd6;
            default: begin
                r.hit = 1'b0;
                r.deg = 3'd0;
            end
        endcase
        return r;
    endfunction

    // degree steps for chord degrees 1, 3, 5, 7, 9, 13
    function automatic logic [4:0] chord_step(input logic [2:0] s);
        logic [4:0] r;
        unique case (s)
            3'd0:    r = 5'd0;
            3'd1:    r = 5'd2;
            3'd2:    r = 5'd4;
            3'd3:    r = 5'd6;
            3'd4:    r = 5'd8;
            3'd5:    r = 5'd12;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // semitones above the tonic of scale step t, octaves included
    function automatic logic [4:0] degree_semis(input logic [4:0] t);
        logic [4:0] r;
        unique case (t)
            5'd0:    r = 5'd0;
            5'd1:    r = 5'd2;
            5'd2:    r = 5'd4;
            5'd3:    r = 5'd5;
            5'd4:    r = 5'd7;
            5'd5:    r = 5'd9;
            5'd6:    r = 5'd11;
            5'd7:    r = 5'd12;
            5'd8:    r = 5'd14;
            5'd9:    r = 5'd16;
            5'd10:   r = 5'd17;
            5'd11:   r = 5'd19;
            5'd12:   r = 5'd21;
            5'd13:   r = 5'd23;
            5'd14:   r = 5'd24;
            5'd15:   r = 5'd26;
            5'd16:   r = 5'd28;
            5'd17:   r = 5'd29;
            5'd18:   r = 5'd31;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/dce_front.sv
// Front end: configuration registers, input stage and event classification.
`default_nettype none
module dce_front
    import dce_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic     i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    output logic          o_push,
    input  wire logic     i_push_ready,
    output t_job          o_job
);

    t_cfg       r_cfg;
    logic       r_valid;
    t_in_item   r_item;

    logic [8:0]  w_biased;
    logic [16:0] w_prod;
    logic [5:0]  w_quot;
    logic [8:0]  w_rem;
    t_deg_hit    w_dh;
    logic        w_is_note;
    logic        w_expand;
    logic        w_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_key       <= BASE_KEY_RESET;
            r_cfg.target_channel <= TARGET_CHANNEL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE_KEY:       r_cfg.base_key       <= i_cfg_data;
                CFG_TARGET_CHANNEL: r_cfg.target_channel <= i_cfg_data[3:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // pitch class of the key relative to the tonic
    always_comb begin
        w_biased = {2'b00, r_item.note_key} + OCTAVE_BIAS - {2'b00, r_cfg.base_key};
        w_prod   = w_biased * MOD12_RECIP;
        w_quot   = w_prod[MOD12_SHIFT +: 6];
        w_rem    = w_biased - 9'(w_quot * SEMIS_OCTAVE);
        w_dh     = pitch_degree(w_rem[3:0]);
    end

    assign w_is_note = (r_item.op == OP_NOTE_ON) || (r_item.op == OP_NOTE_OFF);
    assign w_expand  = w_is_note && (r_item.channel == r_cfg.target_channel) && w_dh.hit;
    assign w_done    = r_valid && (!w_expand || i_push_ready);
    assign o_in_ready = !r_valid || w_done;
    assign o_push     = r_valid && w_expand;

    always_comb begin
        o_job.kind     = r_item.op[0];
        o_job.channel  = r_item.channel;
        o_job.velocity = r_item.velocity;
        o_job.deg      = w_dh.deg;
        o_job.root     = $signed({1'b0, r_item.note_key})
                       - $signed({4'b0000, degree_offset(w_dh.deg)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dce_fifo.sv
// Small flop-based queue between the classifier and the tone generator.
`default_nettype none
module dce_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_wr_en;
    logic             w_rd_en;

    assign o_push_ready = (r_cnt != FULL_CNT);
    assign o_valid      = (r_cnt != '0);
    assign o_data       = r_mem[r_rd];
    assign w_wr_en      = i_push && o_push_ready;
    assign w_rd_en      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : PW'(r_wr + 1'b1);
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : PW'(r_rd + 1'b1);
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (w_rd_en && !w_wr_en) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dce_back.sv
// Back end: walks queue-head chord tones, one per cycle unless stalled.
`default_nettype none
module dce_back
    import dce_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_item o_out_item
);

    localparam logic [2:0] LAST_STEP = 3'(CHORD_TONES - 1);

    logic [2:0]        r_step;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [2:0]        w_next_step;
    logic signed [8:0] w_cur_note;
    logic signed [8:0] w_next_note;
    logic              w_is_last;
    logic              w_fire;

    assign w_next_step = 3'(r_step + 1'b1);

    always_comb begin
        w_cur_note  = {i_job.root[7], i_job.root}
                    + $signed({4'b0000, degree_semis(5'({2'b00, i_job.deg})
                                                     + chord_step(r_step))});
        w_next_note = {i_job.root[7], i_job.root}
                    + $signed({4'b0000, degree_semis(5'({2'b00, i_job.deg})
                                                     + chord_step(w_next_step))});
        // tones ascend, so the first one out of range ends the chord
        w_is_last   = (r_step == LAST_STEP) || (w_next_note > $signed(TOP_NOTE));
    end

    assign w_fire = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_fire && w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_step      <= w_is_last ? '0 : w_next_step;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.out_kind     <= i_job.kind;
            r_out.out_channel  <= i_job.channel;
            r_out.out_key      <= w_cur_note[6:0];
            r_out.out_velocity <= i_job.velocity;
            r_out.last         <= w_is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// File: hw/rtl/diatonic_chord_expander.sv
// Top level of the diatonic chord expander.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one note event
//   per transaction. A note-on or note-off on the target channel whose key lies
//   on the major scale of base_key expands into up to six chord tones (scale
//   degrees 1, 3, 5, 7, 9, 13 above the key), emitted in ascending order on the
//   output channel (o_out_valid / i_out_ready / o_out_item), with last set on
//   the final tone. Tones above note 127 are dropped; all other events vanish.
//   Config channel writes base_key (index 0) or target_channel (index 1); it is
//   always ready. Write it only while the block is idle; nothing enforces this.
// Timing:
//   The first tone passes the input register, the queue and the output register.
//   The tone generator emits one tone per cycle while the output is not stalled;
//   the input stage takes one event per cycle while the queue has room, into a
//   QUEUE_DEPTH-entry queue, and dropped events never reach the queue.
// Reset:
//   Synchronous, active low: queue empty, no output valid, base_key 60,
//   target_channel 0.
// Stall:
//   When i_out_ready is low the output register holds its tone, the generator
//   waits, the queue fills, and then o_in_ready drops.
`default_nettype none
module diatonic_chord_expander
    import dce_pkg::*;
#(
    parameter int QUEUE_DEPTH = DCE_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);

    logic w_push;
    logic w_push_ready;
    t_job w_front_job;
    logic w_head_valid;
    t_job w_head_job;
    logic w_pop;

    // classify and hold one event; push only events that expand
    dce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_job        (w_front_job)
    );

    // decouple the classifier from the tone generator
    dce_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_job))
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_data       (w_front_job),
        .o_valid      (w_head_valid),
        .i_pop        (w_pop),
        .o_data       (w_head_job)
    );

    // emit chord tones of the queue head, pop after the last one
    dce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_head_valid),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// File: hw/rtl/dce_checker.sv
// Port-level checks for the diatonic chord expander, bound to the top level.
`default_nettype none
module dce_checker
    import dce_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // hold a stalled tone
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("output payload changed while stalled");

    // reset clears the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a chord continues with a higher tone of the same event in the next cycle
    a_chord_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last |=>
            o_out_valid
            && (o_out_item.out_key > $past(o_out_item.out_key))
            && (o_out_item.out_channel == $past(o_out_item.out_channel))
            && (o_out_item.out_kind == $past(o_out_item.out_kind))
            && (o_out_item.out_velocity == $past(o_out_item.out_velocity)))
        else $error("chord tone sequence broken");

endmodule

bind diatonic_chord_expander dce_checker u_dce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the diatonic chord expander.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import dce_pkg::*;

    // event kinds that the block must ignore
    localparam logic [1:0] OP_OTHER    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
    localparam int SETTLE_CYCLES = 12;    // pause before a register write
    localparam int LONG_HOLD     = 100;   // receiver hold-off for back-pressure
    localparam int N_SETTINGS    = 8;
    localparam int EVENTS_PER_SETTING = 38;

    // ------------------------------------------------------------------
    // Chord predictor and tone scoreboard
    // ------------------------------------------------------------------
    class chord_scoreboard;
        logic [6:0] tonic;
        logic [3:0] listen_ch;
        int         semis[7];
        int         span[6];
        t_out_item  pending_tones[$];
        int         errors;
        int         events_seen;
        int         chords;
        int         tones_checked;

        function new();
            tonic     = BASE_KEY_RESET;
            listen_ch = TARGET_CHANNEL_RESET;
            semis     = '{0, 2, 4, 5, 7, 9, 11};
            span      = '{0, 2, 4, 6, 8, 12};
            errors = 0;
            events_seen = 0;
            chords = 0;
            tones_checked = 0;
        endfunction

        function void set_reg(logic idx, logic [6:0] data);
            if (idx == CFG_BASE_KEY) begin
                tonic = data;
            end else begin
                listen_ch = data[3:0];
            end
        endfunction

        // scale degree (0..6) of a key under the current tonic, or -1
        function int scale_degree(logic [6:0] key);
            int pc;
            pc = (int'(key) + 132 - int'(tonic)) % 12;
            for (int d = 0; d < 7; d++) begin
                if (semis[d] == pc) return d;
            end
            return -1;
        endfunction

        // predict the chord tones caused by one accepted event
        function void note_event(t_in_item ev);
            int        d;
            int        root;
            int        t;
            int        pitch;
            t_out_item tone;
            events_seen++;
            if (ev.op > OP_NOTE_OFF || ev.channel != listen_ch) return;
            d = scale_degree(ev.note_key);
            if (d < 0) return;
            root = int'(ev.note_key) - semis[d];
            for (int s = 0; s < 6; s++) begin
                t     = d + span[s];
                pitch = root + 12 * (t / 7) + semis[t % 7];
                if (pitch > 127) break;
                tone.out_kind     = ev.op[0];
                tone.out_channel  = ev.channel;
                tone.out_key      = pitch[6:0];
                tone.out_velocity = ev.velocity;
                tone.last         = 1'b0;
                pending_tones = {pending_tones, tone};
            end
            // the key itself never exceeds 127, so at least one tone exists
            pending_tones[pending_tones.size() - 1].last = 1'b1;
            chords++;
        endfunction

        function void compare_field(string name, logic [6:0] want_v, logic [6:0] got_v);
            if (got_v !== want_v) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_tone(t_out_item got);
            t_out_item want;
            if (pending_tones.size() == 0) begin
                $display("%0t ns: unexpected tone, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_tones.pop_front();
            tones_checked++;
            compare_field("out_kind", 7'(want.out_kind), 7'(got.out_kind));
            compare_field("out_channel", 7'(want.out_channel), 7'(got.out_channel));
            compare_field("out_key", want.out_key, got.out_key);
            compare_field("out_velocity", want.out_velocity, got.out_velocity);
            compare_field("last", 7'(want.last), 7'(got.last));
        endfunction

        function void flush_check();
            if (pending_tones.size() != 0) begin
                $display("%0t ns: %0d expected tones never arrived, oldest %p",
                         $time, pending_tones.size(), pending_tones[0]);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and the device under test
    // ------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [6:0] i_cfg_data;

    diatonic_chord_expander uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    chord_scoreboard sb = new();

    bit hold_request = 1'b0;  // ask the receiver for one long hold-off
    bit offering     = 1'b0;  // input valid is currently raised
    int burst_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_event(i_in_item);
            if (o_out_valid && i_out_ready) sb.check_tone(o_out_item);
        end
    end

    // Watchdog: end the run once no transaction happens for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t ns: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a changing pattern, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int window;
        mode   = 0;
        window = 0;
        i_out_ready <= 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // hold off long enough for the queue to fill and stall the input
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (window == 0) begin
                    mode   = $urandom_range(0, 3);
                    window = $urandom_range(10, 60);
                end
                window--;
                case (mode)
                    0: i_out_ready <= 1'b1;                         // no stalls
                    1: i_out_ready <= ($urandom_range(0, 9) < 7);   // light stalls
                    2: i_out_ready <= window[0];                    // alternates ready and stall
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);  // heavy stalls
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------
    task automatic stop_offering();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Present one event, hold it until accepted, then maybe idle for a while.
    task automatic offer_event(input t_in_item ev);
        int gap;
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                stop_offering();
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Hold the write until the register port takes it; caller drops valid.
    task automatic write_reg(input logic idx, input logic [6:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Wait for every predicted tone, then let the pipeline empty out.
    task automatic drain_tones();
        while (sb.pending_tones.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_in_item make_event(logic [1:0] op, logic [3:0] ch,
                                            logic [6:0] key, logic [6:0] vel);
        t_in_item ev;
        ev.op       = op;
        ev.channel  = ch;
        ev.note_key = key;
        ev.velocity = vel;
        return ev;
    endfunction

    // Draw a random event; mostly chord-producing, the rest noise the block drops.
    function automatic t_in_item random_event();
        t_in_item ev;
        int       pick;
        ev.velocity = 7'($urandom_range(0, 127));
        ev.channel  = sb.listen_ch;
        ev.op       = $urandom_range(0, 1) ? OP_NOTE_OFF : OP_NOTE_ON;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // on-scale key; bias some toward the top to exercise dropped tones
            do begin
                ev.note_key = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(100, 127))
                                                          : 7'($urandom_range(0, 127));
            end while (sb.scale_degree(ev.note_key) < 0);
        end else if (pick < 80) begin
            do ev.note_key = 7'($urandom_range(0, 127));
            while (sb.scale_degree(ev.note_key) >= 0);
        end else if (pick < 90) begin
            ev.channel  = sb.listen_ch ^ 4'($urandom_range(1, 15));
            ev.op       = 2'($urandom_range(0, 3));
            ev.note_key = 7'($urandom_range(0, 127));
        end else begin
            ev.op       = $urandom_range(0, 1) ? OP_RESERVED : OP_OTHER;
            ev.note_key = 7'($urandom_range(0, 127));
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_in_item   ev;
        t_in_item   directed_events[$];
        int         sent;
        logic [6:0] new_tonic;
        logic [3:0] new_ch;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BASE_KEY;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed events under the reset setting: C major tonic, channel 0.
        directed_events = '{
            make_event(OP_NOTE_ON,  4'd0,  7'd60,  7'd100),  // tonic, full chord
            make_event(OP_NOTE_OFF, 4'd0,  7'd62,  7'd0),    // second degree, zero velocity
            make_event(OP_NOTE_ON,  4'd0,  7'd71,  7'd127),  // leading tone
            make_event(OP_OTHER,    4'd0,  7'd60,  7'd64),   // other command: nothing
            make_event(OP_RESERVED, 4'd0,  7'd60,  7'd127),  // op three: nothing
            make_event(OP_NOTE_ON,  4'd15, 7'd60,  7'd64),   // wrong channel: nothing
            make_event(OP_NOTE_ON,  4'd0,  7'd61,  7'd64),   // off the scale: nothing
            make_event(OP_NOTE_OFF, 4'd0,  7'd0,   7'd127),  // lowest key
            make_event(OP_NOTE_ON,  4'd0,  7'd127, 7'd90),   // highest key: one tone
            make_event(OP_NOTE_ON,  4'd0,  7'd125, 7'd33),   // rest of chord above 127
            make_event(OP_NOTE_ON,  4'd0,  7'd120, 7'd45),   // three tones fit
            make_event(OP_NOTE_OFF, 4'd0,  7'd115, 7'd77),   // four tones fit
            make_event(OP_NOTE_ON,  4'd0,  7'd1,   7'd1),    // off the scale at the bottom
            make_event(OP_NOTE_OFF, 4'd0,  7'd127, 7'd127)   // highest key, note-off
        };
        foreach (directed_events[i]) offer_event(directed_events[i]);
        stop_offering();
        drain_tones();

        // Random phases, each under its own register setting.
        for (int p = 0; p < N_SETTINGS; p++) begin
            case (p)
                0: begin new_tonic = 7'd0;   new_ch = 4'd15; end
                1: begin new_tonic = 7'd127; new_ch = 4'd0;  end
                2: begin new_tonic = 7'd60;  new_ch = 4'd9;  end
                default: begin
                    new_tonic = 7'($urandom_range(0, 127));
                    new_ch    = 4'($urandom_range(0, 15));
                end
            endcase
            // upper data bits are don't-care for the channel register
            write_reg(CFG_TARGET_CHANNEL, {3'($urandom_range(0, 7)), new_ch});
            write_reg(CFG_BASE_KEY, new_tonic);
            i_cfg_valid <= 1'b0;
            @(negedge i_clk);

            sent = 0;
            while (sent < EVENTS_PER_SETTING) begin
                ev = random_event();
                // one long receiver hold-off while the sender keeps offering
                if (p == 2 && sent == 5) hold_request = 1'b1;
                offer_event(ev);
                sent++;
            end
            stop_offering();
            drain_tones();
        end

        sb.flush_check();
        $display("Sent %0d note events over %0d register settings, %0d of them expanded.",
                 sb.events_seen, N_SETTINGS + 1, sb.chords);
        $display("Checked %0d chord tones under random stalls and one %0d-cycle hold-off.",
                 sb.tones_checked, LONG_HOLD);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/dce_pkg.sv
hw/rtl/dce_front.sv
hw/rtl/dce_fifo.sv
hw/rtl/dce_back.sv
hw/rtl/diatonic_chord_expander.sv
hw/rtl/dce_checker.sv
test/testbench.sv
